// ----- src/ovns_pkg.sv -----
// Shared types, codes and constants of the octave value noise sampler.
package ovns_pkg;

	localparam int DATA_W          = 16;
	localparam int COORD_W         = 6;
	localparam int STATUS_W        = 2;
	localparam int CFG_DATA_W      = 7;
	localparam int CFG_INDEX_W     = 2;
	localparam int QUO_W           = 17;
	localparam int DCNT_W          = $clog2(QUO_W);
	localparam int S_TDATA_W       = 32;
	localparam int M_TDATA_W       = 16;

	localparam int DEF_MAX_SIDE    = 64;
	localparam int DEF_MAX_OCTAVES = 7;

	localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH   = 7'd64;
	localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT  = 7'd64;
	localparam logic [2:0]            RST_OCTAVE_COUNT = 3'd6;
	localparam logic [2:0]            RST_MIN_OCTAVE   = 3'd0;

	localparam logic KIND_STORE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_GRID_WIDTH   = 2'd0,
		REG_GRID_HEIGHT  = 2'd1,
		REG_OCTAVE_COUNT = 2'd2,
		REG_MIN_OCTAVE   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ALU_HOLD,
		ALU_MUL,
		ALU_MAC,
		ALU_LOAD,
		ALU_DIV
	} alu_op_t;

	typedef struct packed {
		alu_op_t op;
	} alu_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_OCT,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_DIVI,
		ST_DIV,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic                push;
		logic [DATA_W-1:0]   noise;
		logic [STATUS_W-1:0] status;
	} res_t;

endpackage

// ----- src/ovns_store.sv -----
// Base noise sample memory: one write port, one registered read port.
module ovns_store #(
	parameter int DEPTH = ovns_pkg::DEF_MAX_SIDE * ovns_pkg::DEF_MAX_SIDE,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ovns_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              raddr,
	output logic [ovns_pkg::DATA_W-1:0] rdata
);

	logic [ovns_pkg::DATA_W-1:0] mem [DEPTH];
	logic [ovns_pkg::DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- src/ovns_alu.sv -----
// Shared unit: multiply, multiply-accumulate, load and restoring divide step.
module ovns_alu #(
	parameter int RW = 30,
	parameter int TW = 22,
	parameter int PW = 7
) (
	input  logic               clk,
	input  ovns_pkg::alu_ctl_t ctl,
	input  logic [RW-1:0]      a,
	input  logic [PW-1:0]      b,
	output logic [RW-1:0]      acc,
	output logic               ge
);

	localparam int MW = TW + PW;

	logic [RW-1:0] acc_q;
	logic [MW-1:0] prod;

	assign prod = MW'(a[TW-1:0]) * MW'(b);
	// divide step: a carries the shifted divisor
	assign ge   = (acc_q >= a);

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			ovns_pkg::ALU_HOLD: acc_q <= acc_q;
			ovns_pkg::ALU_MUL:  acc_q <= RW'(prod);
			ovns_pkg::ALU_MAC:  acc_q <= acc_q + RW'(prod);
			ovns_pkg::ALU_LOAD: acc_q <= a;
			ovns_pkg::ALU_DIV:  acc_q <= ge ? (acc_q - a) : acc_q;
			default:            acc_q <= acc_q;
		endcase
	end

	assign acc = acc_q;

endmodule

// ----- src/ovns_seq.sv -----
// Sequencer: octave loop, corner addressing, blend and divide scheduling.
module ovns_seq #(
	parameter int MAX_SIDE    = ovns_pkg::DEF_MAX_SIDE,
	parameter int MAX_OCTAVES = ovns_pkg::DEF_MAX_OCTAVES,
	parameter int GW          = $clog2(MAX_SIDE + 1),
	parameter int OW          = $clog2(MAX_OCTAVES + 1),
	parameter int CW          = $clog2(MAX_SIDE),
	parameter int AW          = $clog2(MAX_SIDE * MAX_SIDE),
	parameter int RW          = ovns_pkg::DATA_W + 2 * MAX_OCTAVES,
	parameter int TW          = ovns_pkg::DATA_W + MAX_OCTAVES - 1,
	parameter int PW          = MAX_OCTAVES
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         in_kind,
	input  logic [ovns_pkg::COORD_W-1:0] in_col,
	input  logic [ovns_pkg::COORD_W-1:0] in_row,
	input  logic [ovns_pkg::DATA_W-1:0]  in_sample,
	input  logic [GW-1:0]                w_eff,
	input  logic [GW-1:0]                h_eff,
	input  logic [OW-1:0]                cnt_eff,
	input  logic [2:0]                   min_oct,
	input  logic                         out_free,
	output ovns_pkg::res_t               res,
	output logic                         mem_we,
	output logic [AW-1:0]                mem_waddr,
	output logic [ovns_pkg::DATA_W-1:0]  mem_wdata,
	output logic [AW-1:0]                mem_raddr,
	input  logic [ovns_pkg::DATA_W-1:0]  mem_rdata,
	output ovns_pkg::alu_ctl_t           alu_ctl,
	output logic [RW-1:0]                alu_a,
	output logic [PW-1:0]                alu_b,
	input  logic [RW-1:0]                alu_acc,
	input  logic                         alu_ge
);

	localparam int XW = (GW > ovns_pkg::COORD_W) ? GW : ovns_pkg::COORD_W;
	localparam int KW = (OW > 3) ? OW : 3;
	localparam int LW = XW + MAX_OCTAVES;
	localparam int SW = RW - 1;
	localparam int DCNT_LOCAL_W = ovns_pkg::DCNT_W;

	function automatic logic [AW-1:0] grid_addr(input logic [CW-1:0] c,
		input logic [CW-1:0] r);
		return AW'(r) * AW'(MAX_SIDE) + AW'(c);
	endfunction

	ovns_pkg::seq_state_t state_q, state_d;

	logic [ovns_pkg::COORD_W-1:0]  col_q, row_q;
	logic [OW-1:0]                 o_q;
	logic [GW-1:0]                 pmx_q, pmy_q;
	logic [CW-1:0]                 c0_q, c1_q, r0_q, r1_q;
	logic [PW-1:0]                 p_q, fx_q, fy_q;
	logic [TW-1:0]                 top_q, bot_q;
	logic [SW-1:0]                 sum_q;
	logic [RW-1:0]                 dv_q;
	logic [DCNT_LOCAL_W-1:0]       dcnt_q;
	logic [ovns_pkg::QUO_W-1:0]    q_q;
	logic [ovns_pkg::DATA_W-1:0]   noise_q;
	logic [ovns_pkg::STATUS_W-1:0] status_q;

	logic [XW-1:0]  col_x, row_x;
	logic [LW-1:0]  lmask;
	logic [XW-1:0]  c0_x, r0_x;
	logic [GW:0]    c1_s, r1_s, c1_w, r1_w;
	logic [GW:0]    pmx_dbl, pmy_dbl;
	logic [GW-1:0]  pmx_n, pmy_n;
	logic           outside, empty, below_min, oct_done, store_ok;
	logic [RW-1:0]  t1, tot, num;
	logic [ovns_pkg::QUO_W-1:0] q_n;

	// octave geometry for the current o_q
	assign col_x   = XW'(col_q);
	assign row_x   = XW'(row_q);
	assign lmask   = (LW'(1) << o_q) - LW'(1);
	assign c0_x    = col_x & ~lmask[XW-1:0];
	assign r0_x    = row_x & ~lmask[XW-1:0];
	// next corner: c0 + (2^o mod w), wrapped once
	assign c1_s    = (GW+1)'(c0_x) + (GW+1)'(pmx_q);
	assign r1_s    = (GW+1)'(r0_x) + (GW+1)'(pmy_q);
	assign c1_w    = (c1_s >= (GW+1)'(w_eff)) ? c1_s - (GW+1)'(w_eff) : c1_s;
	assign r1_w    = (r1_s >= (GW+1)'(h_eff)) ? r1_s - (GW+1)'(h_eff) : r1_s;
	// 2^(o+1) mod w from 2^o mod w
	assign pmx_dbl = {pmx_q, 1'b0};
	assign pmy_dbl = {pmy_q, 1'b0};
	assign pmx_n   = GW'((pmx_dbl >= (GW+1)'(w_eff)) ? pmx_dbl - (GW+1)'(w_eff) : pmx_dbl);
	assign pmy_n   = GW'((pmy_dbl >= (GW+1)'(h_eff)) ? pmy_dbl - (GW+1)'(h_eff) : pmy_dbl);

	assign outside   = (XW'(col_q) >= XW'(w_eff)) || (XW'(row_q) >= XW'(h_eff));
	assign empty     = (KW'(min_oct) >= KW'(cnt_eff));
	assign below_min = (KW'(o_q) < KW'(min_oct));
	assign oct_done  = (o_q == cnt_eff);
	assign store_ok  = (XW'(in_col) < XW'(MAX_SIDE)) && (XW'(in_row) < XW'(MAX_SIDE));

	// total weight 2^(cnt-1) * (2^cnt - 2^min), numerator 2*sum + tot
	assign t1  = (RW'(1) << cnt_eff) - (RW'(1) << min_oct);
	assign tot = t1 << (cnt_eff - OW'(1));
	assign num = {sum_q, 1'b0} + tot;
	assign q_n = {q_q[ovns_pkg::QUO_W-2:0], alu_ge};

	assign mem_waddr = grid_addr(CW'(in_col), CW'(in_row));
	assign mem_wdata = in_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ovns_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mem_we      = 1'b0;
		mem_raddr   = grid_addr(c0_q, r0_q);
		alu_ctl.op  = ovns_pkg::ALU_HOLD;
		alu_a       = '0;
		alu_b       = '0;
		res.push    = 1'b0;
		res.noise   = noise_q;
		res.status  = status_q;
		unique case (state_q)
			ovns_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_kind == ovns_pkg::KIND_QUERY) begin
						state_d = ovns_pkg::ST_CHECK;
					end else begin
						mem_we = store_ok;
					end
				end
			end
			ovns_pkg::ST_CHECK: begin
				state_d = (outside || empty) ? ovns_pkg::ST_OUT : ovns_pkg::ST_OCT;
			end
			ovns_pkg::ST_OCT: begin
				if (oct_done) begin
					state_d = ovns_pkg::ST_DIVI;
				end else if (!below_min) begin
					state_d = ovns_pkg::ST_RD0;
				end
			end
			ovns_pkg::ST_RD0: begin
				mem_raddr = grid_addr(c0_q, r0_q);
				state_d   = ovns_pkg::ST_RD1;
			end
			ovns_pkg::ST_RD1: begin
				mem_raddr  = grid_addr(c1_q, r0_q);
				alu_ctl.op = ovns_pkg::ALU_MUL;
				alu_a      = RW'(mem_rdata);
				alu_b      = p_q - fx_q;
				state_d    = ovns_pkg::ST_RD2;
			end
			ovns_pkg::ST_RD2: begin
				mem_raddr  = grid_addr(c0_q, r1_q);
				alu_ctl.op = ovns_pkg::ALU_MAC;
				alu_a      = RW'(mem_rdata);
				alu_b      = fx_q;
				state_d    = ovns_pkg::ST_RD3;
			end
			ovns_pkg::ST_RD3: begin
				mem_raddr  = grid_addr(c1_q, r1_q);
				alu_ctl.op = ovns_pkg::ALU_MUL;
				alu_a      = RW'(mem_rdata);
				alu_b      = p_q - fx_q;
				state_d    = ovns_pkg::ST_M0;
			end
			ovns_pkg::ST_M0: begin
				alu_ctl.op = ovns_pkg::ALU_MAC;
				alu_a      = RW'(mem_rdata);
				alu_b      = fx_q;
				state_d    = ovns_pkg::ST_M1;
			end
			ovns_pkg::ST_M1: begin
				alu_ctl.op = ovns_pkg::ALU_MUL;
				alu_a      = RW'(top_q);
				alu_b      = p_q - fy_q;
				state_d    = ovns_pkg::ST_M2;
			end
			ovns_pkg::ST_M2: begin
				alu_ctl.op = ovns_pkg::ALU_MAC;
				alu_a      = RW'(bot_q);
				alu_b      = fy_q;
				state_d    = ovns_pkg::ST_M3;
			end
			ovns_pkg::ST_M3: begin
				state_d = ovns_pkg::ST_OCT;
			end
			ovns_pkg::ST_DIVI: begin
				alu_ctl.op = ovns_pkg::ALU_LOAD;
				alu_a      = num;
				state_d    = ovns_pkg::ST_DIV;
			end
			ovns_pkg::ST_DIV: begin
				alu_ctl.op = ovns_pkg::ALU_DIV;
				alu_a      = dv_q;
				if (dcnt_q == '0) begin
					state_d = ovns_pkg::ST_OUT;
				end
			end
			ovns_pkg::ST_OUT: begin
				res.push = 1'b1;
				if (out_free) begin
					state_d = ovns_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ovns_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_q <= '0;
		end else begin
			unique case (state_q)
				ovns_pkg::ST_CHECK: o_q <= '0;
				ovns_pkg::ST_OCT:   o_q <= (!oct_done && below_min) ? o_q + OW'(1) : o_q;
				ovns_pkg::ST_M3:    o_q <= o_q + OW'(1);
				default:            o_q <= o_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ovns_pkg::ST_IDLE: begin
				if (in_valid && in_kind == ovns_pkg::KIND_QUERY) begin
					col_q <= in_col;
					row_q <= in_row;
				end
			end
			ovns_pkg::ST_CHECK: begin
				noise_q  <= '0;
				status_q <= outside ? ovns_pkg::STATUS_OUTSIDE :
				            empty   ? ovns_pkg::STATUS_EMPTY : ovns_pkg::STATUS_OK;
				pmx_q    <= (w_eff == GW'(1)) ? '0 : GW'(1);
				pmy_q    <= (h_eff == GW'(1)) ? '0 : GW'(1);
				sum_q    <= '0;
			end
			ovns_pkg::ST_OCT: begin
				if (!oct_done) begin
					if (below_min) begin
						pmx_q <= pmx_n;
						pmy_q <= pmy_n;
					end else begin
						c0_q <= CW'(c0_x);
						r0_q <= CW'(r0_x);
						c1_q <= CW'(c1_w);
						r1_q <= CW'(r1_w);
						fx_q <= PW'(col_x & lmask[XW-1:0]);
						fy_q <= PW'(row_x & lmask[XW-1:0]);
						p_q  <= PW'(1) << o_q;
					end
				end
			end
			ovns_pkg::ST_RD3: top_q <= TW'(alu_acc);
			ovns_pkg::ST_M1:  bot_q <= TW'(alu_acc);
			ovns_pkg::ST_M3: begin
				// Horner over octaves: lower octaves end up shifted further
				sum_q <= {sum_q[SW-2:0], 1'b0} + SW'(alu_acc);
				pmx_q <= pmx_n;
				pmy_q <= pmy_n;
			end
			ovns_pkg::ST_DIVI: begin
				dv_q   <= tot << ovns_pkg::QUO_W;
				dcnt_q <= DCNT_LOCAL_W'(ovns_pkg::QUO_W - 1);
				q_q    <= '0;
			end
			ovns_pkg::ST_DIV: begin
				q_q    <= q_n;
				dv_q   <= dv_q >> 1;
				dcnt_q <= dcnt_q - DCNT_LOCAL_W'(1);
				if (dcnt_q == '0) begin
					noise_q  <= q_n[ovns_pkg::QUO_W-1] ? '1 : q_n[ovns_pkg::DATA_W-1:0];
					status_q <= ovns_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- src/octave_value_noise_sampler_unit.sv -----
// Top level: config registers, sample store, shared unit, sequencer, output register.
// Store transfer: written at the accepting edge, ready again the next cycle.
// Query transfer: a check state, skip steps in OCT for octaves below min_octave, then
//   OCT, RD0..RD3 and M0..M3 per summed octave, normalize/divide and the output register.
//   The hand-off waits while the output register is full. One item at a time.
// arst_n clears the control state and loads the config defaults; samples are not cleared.
module octave_value_noise_sampler_unit #(
	parameter int MAX_SIDE    = ovns_pkg::DEF_MAX_SIDE,
	parameter int MAX_OCTAVES = ovns_pkg::DEF_MAX_OCTAVES
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// col [5:0], row [11:6], sample [27:12], zero [31:28]
	input  logic [ovns_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// kind [0]: 0 store sample, 1 query point
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// noise_value [15:0]
	output logic [ovns_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// status [1:0]
	output logic [ovns_pkg::STATUS_W-1:0]       m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ovns_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ovns_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int GW    = $clog2(MAX_SIDE + 1);
	localparam int OW    = $clog2(MAX_OCTAVES + 1);
	localparam int CW    = $clog2(MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = ovns_pkg::DATA_W + 2 * MAX_OCTAVES;
	localparam int TW    = ovns_pkg::DATA_W + MAX_OCTAVES - 1;
	localparam int PW    = MAX_OCTAVES;
	localparam int ZW    = (GW > ovns_pkg::CFG_DATA_W) ? GW : ovns_pkg::CFG_DATA_W;
	localparam int KW    = (OW > 3) ? OW : 3;

	// ---- configuration registers, always writable
	logic [ovns_pkg::CFG_DATA_W-1:0] grid_width_q, grid_height_q;
	logic [2:0]                      octave_count_q, min_octave_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q   <= ovns_pkg::RST_GRID_WIDTH;
			grid_height_q  <= ovns_pkg::RST_GRID_HEIGHT;
			octave_count_q <= ovns_pkg::RST_OCTAVE_COUNT;
			min_octave_q   <= ovns_pkg::RST_MIN_OCTAVE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ovns_pkg::cfg_reg_t'(cfg_index))
				ovns_pkg::REG_GRID_WIDTH:   grid_width_q   <= cfg_data;
				ovns_pkg::REG_GRID_HEIGHT:  grid_height_q  <= cfg_data;
				ovns_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_data[2:0];
				ovns_pkg::REG_MIN_OCTAVE:   min_octave_q   <= cfg_data[2:0];
				default: begin
				end
			endcase
		end
	end

	// ---- effective config: sizes clamp to MAX_SIDE, count clamps to MAX_OCTAVES
	logic [GW-1:0] w_eff, h_eff;
	logic [OW-1:0] cnt_eff;

	assign w_eff   = (ZW'(grid_width_q) > ZW'(MAX_SIDE)) ? GW'(MAX_SIDE) : GW'(grid_width_q);
	assign h_eff   = (ZW'(grid_height_q) > ZW'(MAX_SIDE)) ? GW'(MAX_SIDE) : GW'(grid_height_q);
	assign cnt_eff = (KW'(octave_count_q) > KW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
	                                                         : OW'(octave_count_q);

	// ---- datapath pieces
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr, mem_raddr;
	logic [ovns_pkg::DATA_W-1:0] mem_wdata, mem_rdata;
	ovns_pkg::alu_ctl_t          alu_ctl;
	logic [RW-1:0]               alu_a, alu_acc;
	logic [PW-1:0]               alu_b;
	logic                        alu_ge;
	ovns_pkg::res_t              res;
	logic                        out_free;

	ovns_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	ovns_alu #(
		.RW (RW),
		.TW (TW),
		.PW (PW)
	) u_alu (
		.clk (clk),
		.ctl (alu_ctl),
		.a   (alu_a),
		.b   (alu_b),
		.acc (alu_acc),
		.ge  (alu_ge)
	);

	ovns_seq #(
		.MAX_SIDE    (MAX_SIDE),
		.MAX_OCTAVES (MAX_OCTAVES),
		.GW          (GW),
		.OW          (OW),
		.CW          (CW),
		.AW          (AW),
		.RW          (RW),
		.TW          (TW),
		.PW          (PW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_col    (s_axis_tdata[5:0]),
		.in_row    (s_axis_tdata[11:6]),
		.in_sample (s_axis_tdata[27:12]),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.cnt_eff   (cnt_eff),
		.min_oct   (min_octave_q),
		.out_free  (out_free),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.alu_ctl   (alu_ctl),
		.alu_a     (alu_a),
		.alu_b     (alu_b),
		.alu_acc   (alu_acc),
		.alu_ge    (alu_ge)
	);

	// ---- output register: holds a result while the sequencer takes the next transfer
	logic                          out_valid_q;
	logic [ovns_pkg::DATA_W-1:0]   out_noise_q;
	logic [ovns_pkg::STATUS_W-1:0] out_status_q;

	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res.push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res.push) begin
			out_noise_q  <= res.noise;
			out_status_q <= res.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_noise_q;
	assign m_axis_tuser  = out_status_q;

endmodule

// ----- src/ovns_checker.sv -----
// Port-level checker for the noise sampler, bound to the top level.
module ovns_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic                              s_axis_tuser,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ovns_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	input logic [ovns_pkg::STATUS_W-1:0]     m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// error results carry zero noise
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ovns_pkg::STATUS_OK |-> m_axis_tdata == '0)
		else $error("nonzero noise with error status");

	// query transfer starts the engine, which is busy the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ovns_pkg::KIND_QUERY
			|=> !s_axis_tready)
		else $error("ready after query transfer");

	// store transfer leaves the input ready again the next cycle
	a_store_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser == ovns_pkg::KIND_STORE
			|=> s_axis_tready)
		else $error("not ready after store transfer");

endmodule

bind octave_value_noise_sampler_unit ovns_checker u_ovns_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for octave_value_noise_sampler_unit: stream driver, monitor, predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Timeout in clock cycles.
	localparam int unsigned RUN_LIMIT  = 2_000_000;
	// Cycles to let pass after the last result before reconfiguring or ending.
	localparam int unsigned DRAIN_WAIT = 100;
	localparam int unsigned SIDE       = ovns_pkg::DEF_MAX_SIDE;
	localparam int unsigned OCTAVES    = ovns_pkg::DEF_MAX_OCTAVES;
	localparam int unsigned CELLS      = SIDE * SIDE;
	localparam int          CW         = ovns_pkg::COORD_W;
	localparam int          DW         = ovns_pkg::DATA_W;
	localparam int          RW         = ovns_pkg::CFG_DATA_W;

	// One operation on the input stream: a sample store or a noise query.
	typedef struct {
		logic          kind;
		logic [CW-1:0] col;
		logic [CW-1:0] row;
		logic [DW-1:0] smp;
		bit            hold;   // wait for all owed results before presenting this one
	} sampler_op_t;

	typedef struct packed {
		logic [DW-1:0]                 noise;
		logic [ovns_pkg::STATUS_W-1:0] status;
	} noise_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [ovns_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic                             s_axis_tuser = 1'b0;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [ovns_pkg::M_TDATA_W-1:0]   m_axis_tdata;
	logic [ovns_pkg::STATUS_W-1:0]    m_axis_tuser;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [ovns_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [RW-1:0]                    cfg_data = '0;

	// Operations waiting for the driver, and query results still owed by the block.
	sampler_op_t sample_ops[$];
	noise_res_t  expected_noise[$];

	// Predictor state: sample image and register copies, updated at each transfer.
	logic [DW-1:0] base_img [CELLS];
	logic [RW-1:0] grid_w  = ovns_pkg::RST_GRID_WIDTH;
	logic [RW-1:0] grid_h  = ovns_pkg::RST_GRID_HEIGHT;
	logic [2:0]    oct_cnt = ovns_pkg::RST_OCTAVE_COUNT;
	logic [2:0]    oct_min = ovns_pkg::RST_MIN_OCTAVE;

	// Cells the stimulus has already scheduled a store for; queries only touch these.
	bit planned_cells [CELLS];

	int unsigned queries_sent = 0;   // blocking, driver only
	int unsigned results_seen = 0;   // nonblocking, monitor only
	int unsigned owed;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;      // no idling on either side while set

	octave_value_noise_sampler_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Grid size registers above the store side act as the full side.
	function automatic int unsigned used_side(logic [RW-1:0] s);
		return (s > SIDE) ? SIDE : s;
	endfunction

	// Lower corner of one axis at a given octave, and the next corner with wrap.
	function automatic void span_corners(int unsigned pos, int unsigned oct, int unsigned side,
		output int unsigned lo, output int unsigned hi);
		int unsigned p;
		p  = 1 << oct;
		lo = pos & ~(p - 1);
		hi = (lo + p) % side;
	endfunction

	// Fractal noise at (col,row) under the current register copies. Exact integer math:
	// each octave blend is scaled by P*P, shifted by (cnt-1-o), weight 2^(cnt-1+o).
	function automatic noise_res_t predict_noise(int unsigned col, int unsigned row);
		noise_res_t  res;
		int unsigned w, h, cnt, p, c0, c1, r0, r1, fx, fy;
		logic [63:0] acc, wsum, top, bot, q;
		w   = used_side(grid_w);
		h   = used_side(grid_h);
		cnt = (oct_cnt > OCTAVES) ? OCTAVES : oct_cnt;
		res.noise = '0;
		// outside check wins over the empty octave range
		if (col >= w || row >= h) begin
			res.status = ovns_pkg::STATUS_OUTSIDE;
			return res;
		end
		if (oct_min >= cnt) begin
			res.status = ovns_pkg::STATUS_EMPTY;
			return res;
		end
		acc  = '0;
		wsum = '0;
		for (int unsigned o = oct_min; o < cnt; o++) begin
			p = 1 << o;
			span_corners(col, o, w, c0, c1);
			span_corners(row, o, h, r0, r1);
			fx  = col - c0;
			fy  = row - r0;
			top = 64'(base_img[r0*SIDE+c0]) * (p - fx)
				+ 64'(base_img[r0*SIDE+c1]) * fx;
			bot = 64'(base_img[r1*SIDE+c0]) * (p - fx)
				+ 64'(base_img[r1*SIDE+c1]) * fx;
			acc  += (top * (p - fy) + bot * fy) << (cnt - 1 - o);
			wsum += 64'd1 << (cnt - 1 + o);
		end
		// round half up, then saturate
		q = (2 * acc + wsum) / (2 * wsum);
		res.noise  = (q > 64'hFFFF) ? 16'hFFFF : q[DW-1:0];
		res.status = ovns_pkg::STATUS_OK;
		return res;
	endfunction

	task automatic add_store(int unsigned col, int unsigned row, logic [DW-1:0] smp);
		sample_ops.push_back('{ovns_pkg::KIND_STORE, CW'(col), CW'(row), smp, 1'b0});
		planned_cells[row*SIDE+col] = 1'b1;
	endtask

	task automatic fill_cell(int unsigned col, int unsigned row);
		if (!planned_cells[row*SIDE+col])
			add_store(col, row, 16'($urandom));
	endtask

	// Queue a query; first store any corner it will read that was never written.
	task automatic add_query(int unsigned col, int unsigned row, bit hold = 1'b0);
		int unsigned w, h, c0, c1, r0, r1;
		w = used_side(grid_w);
		h = used_side(grid_h);
		if (col < w && row < h && oct_min < oct_cnt) begin
			for (int unsigned o = oct_min; o < oct_cnt; o++) begin
				span_corners(col, o, w, c0, c1);
				span_corners(row, o, h, r0, r1);
				fill_cell(c0, r0);
				fill_cell(c1, r0);
				fill_cell(c0, r1);
				fill_cell(c1, r1);
			end
		end
		// the sample bits of a query are don't-care; random keeps them toggling
		sample_ops.push_back('{ovns_pkg::KIND_QUERY, CW'(col), CW'(row), 16'($urandom), hold});
	endtask

	// Mix of stores anywhere and queries mostly inside the grid; about n items in all,
	// corner fills included.
	task automatic random_ops(int unsigned n);
		int unsigned w, h, col, row, target;
		w = used_side(grid_w);
		h = used_side(grid_h);
		target = sample_ops.size() + n;
		while (sample_ops.size() < target) begin
			if ($urandom_range(0, 99) < 35) begin
				add_store($urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom));
			end else begin
				if (w != 0 && h != 0 && $urandom_range(0, 99) < 85) begin
					col = $urandom_range(0, w - 1);
					row = $urandom_range(0, h - 1);
				end else begin
					col = $urandom_range(0, 63);
					row = $urandom_range(0, 63);
				end
				// now and then hold off until the block has drained
				add_query(col, row, $urandom_range(0, 79) == 0);
			end
		end
	endtask

	// Wait until every queued op is transferred and every owed result is back.
	task automatic settle();
		while (sample_ops.size() != 0 || queries_sent != results_seen)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(ovns_pkg::cfg_reg_t idx, logic [RW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			ovns_pkg::REG_GRID_WIDTH:   grid_w  = val;
			ovns_pkg::REG_GRID_HEIGHT:  grid_h  = val;
			ovns_pkg::REG_OCTAVE_COUNT: oct_cnt = val[2:0];
			ovns_pkg::REG_MIN_OCTAVE:   oct_min = val[2:0];
			default: ;
		endcase
	endtask

	// Reconfigure only once the block is idle. Octave registers get junk in
	// their unused upper data bits.
	task automatic reconfigure(logic [RW-1:0] w, logic [RW-1:0] h,
		logic [2:0] cnt, logic [2:0] mn, bit calm);
		settle();
		steady <= calm;
		write_reg(ovns_pkg::REG_GRID_WIDTH, w);
		write_reg(ovns_pkg::REG_GRID_HEIGHT, h);
		write_reg(ovns_pkg::REG_OCTAVE_COUNT, {4'($urandom), cnt});
		write_reg(ovns_pkg::REG_MIN_OCTAVE, {4'($urandom), mn});
	endtask

	function automatic logic [RW-1:0] rand_side();
		case ($urandom_range(0, 9))
			0:       return 7'($urandom_range(65, 127));
			1:       return 7'($urandom_range(1, 4));
			default: return 7'($urandom_range(1, 64));
		endcase
	endfunction

	// Input driver: presents the head of sample_ops, predicts at each transfer.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			owed = queries_sent - results_seen;
			if (s_axis_tvalid) begin
				// transfer at this edge
				if (sample_ops[0].kind == ovns_pkg::KIND_QUERY) begin
					expected_noise.push_back(predict_noise(sample_ops[0].col,
						sample_ops[0].row));
					queries_sent++;
					owed++;
				end else begin
					base_img[sample_ops[0].row*SIDE+sample_ops[0].col] = sample_ops[0].smp;
				end
				void'(sample_ops.pop_front());
			end
			if (sample_ops.size() != 0 && !(sample_ops[0].hold && owed != 0)
				&& (steady || $urandom_range(0, 99) >= 17)) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'b0, sample_ops[0].smp, sample_ops[0].row, sample_ops[0].col};
				s_axis_tuser  <= sample_ops[0].kind;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Output monitor: checks each transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : result_check
		noise_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (expected_noise.size() == 0) begin
					$error("unexpected result: noise_value %h status %0d", m_axis_tdata,
						m_axis_tuser);
					mismatches++;
				end else begin
					want = expected_noise.pop_front();
					if (m_axis_tdata !== want.noise) begin
						$error("noise_value: expected %h, got %h", want.noise, m_axis_tdata);
						mismatches++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						mismatches++;
					end
				end
			end
			m_axis_tready <= steady || ($urandom_range(0, 99) >= 17);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("octave_value_noise_sampler_unit: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		logic [2:0] cnt_pick, min_pick;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: 64x64 grid, octaves 0..5. Sample extremes, grid corners.
		add_store(0, 0, 16'h0000);
		add_store(63, 63, 16'hFFFF);
		add_store(63, 0, 16'hFFFF);
		add_store(0, 63, 16'h0000);
		add_query(0, 0);
		add_query(63, 63);
		add_query(63, 0, 1'b1);
		add_query(0, 63);
		add_query(32, 31);
		add_store(32, 32, 16'h8000);
		add_query(33, 33);
		random_ops(100);

		// Zero height: every query outside; oversized width clamps to the store side.
		reconfigure(7'd127, 7'd0, 3'd7, 3'd3, 1'b0);
		add_query(0, 0);
		add_query(63, 63);
		add_store(5, 5, 16'hA5A5);
		random_ops(30);

		// Empty octave range; outside check still comes first.
		reconfigure(7'd17, 7'd5, 3'd7, 3'd7, 1'b0);
		add_query(16, 4);
		add_query(17, 4);
		add_store(63, 63, 16'h5A5A);
		random_ops(30);

		// Octave count of zero, width just above the side.
		reconfigure(7'd65, 7'd33, 3'd0, 3'd0, 1'b0);
		add_query(63, 32);
		add_query(63, 33);
		random_ops(30);

		// Smallest grid and a single octave.
		reconfigure(7'd1, 7'd1, 3'd1, 3'd0, 1'b0);
		add_query(0, 0);
		add_query(1, 0);
		add_query(0, 1);
		random_ops(60);

		// All seven octaves, both sides running with no idling.
		reconfigure(7'd64, 7'd64, 3'd7, 3'd0, 1'b1);
		add_query(63, 63);
		add_query(0, 0);
		random_ops(150);

		// Top octave only.
		reconfigure(7'd64, 7'd64, 3'd7, 3'd6, 1'b0);
		random_ops(100);

		repeat (7) begin
			cnt_pick = 3'($urandom_range(1, 7));
			min_pick = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, cnt_pick - 1));
			reconfigure(rand_side(), rand_side(), cnt_pick, min_pick, 1'b0);
			random_ops(100);
		end

		settle();
		if (mismatches == 0)
			$display("octave_value_noise_sampler_unit: match");
		else
			$display("octave_value_noise_sampler_unit: mismatch");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/ovns_pkg.sv
src/ovns_store.sv
src/ovns_alu.sv
src/ovns_seq.sv
src/octave_value_noise_sampler_unit.sv
src/ovns_checker.sv
tb/tb_top.sv
